// ===== rtl/pfc_pkg.sv =====
// shared types, format codes and scaling helpers for the pixel format converter
package pfc_pkg;

    localparam int NUM_LANES = 3;
    localparam int CHAN_W    = 8;
    localparam int NUM_W     = 17;
    localparam int RECIP_W   = 26;
    localparam int RECIP_SH  = 26;
    localparam int FMT_W     = 4;
    localparam int PIX_W     = 32;

    localparam logic [FMT_W-1:0] FMT_RGB555 = 4'd0;
    localparam logic [FMT_W-1:0] FMT_RGB565 = 4'd1;
    localparam logic [FMT_W-1:0] FMT_RGB888 = 4'd2;
    localparam logic [FMT_W-1:0] FMT_RGB111 = 4'd3;
    localparam logic [FMT_W-1:0] FMT_RGB222 = 4'd4;
    localparam logic [FMT_W-1:0] FMT_ARGB   = 4'd5;
    localparam logic [FMT_W-1:0] FMT_GREY2  = 4'd6;
    localparam logic [FMT_W-1:0] FMT_GREY3  = 4'd7;
    localparam logic [FMT_W-1:0] FMT_GREY4  = 4'd8;

    localparam logic REG_SOURCE_FORMAT = 1'b0;
    localparam logic REG_TARGET_FORMAT = 1'b1;

    localparam logic [FMT_W-1:0] RESET_SOURCE = FMT_RGB888;
    localparam logic [FMT_W-1:0] RESET_TARGET = FMT_RGB565;

    localparam logic [PIX_W-1:0] NOT_GREY_PIXEL = 32'd255;
    localparam logic [7:0]       ALPHA_OPAQUE   = 8'hFF;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [FMT_W-1:0]  fmt_t;

    typedef struct packed {
        logic load_num;
        logic load_quo;
    } lane_ctl_t;

    // full-scale value of one lane's channel in a target format
    function automatic chan_t target_max(input fmt_t fmt, input logic [1:0] lane);
        chan_t m;
        begin
            unique case (fmt)
                FMT_RGB555: m = 8'd31;
                FMT_RGB565: m = (lane == 2'd1) ? 8'd63 : 8'd31;
                FMT_RGB888,
                FMT_ARGB:   m = 8'd255;
                FMT_RGB111: m = 8'd1;
                FMT_RGB222: m = 8'd3;
                FMT_GREY2:  m = 8'd3;
                FMT_GREY3:  m = 8'd7;
                FMT_GREY4:  m = 8'd15;
                default:    m = 8'd1;
            endcase
            return m;
        end
    endfunction

    // ceil(2^26 / (2*max)): exact quotient for 17-bit numerators
    function automatic logic [RECIP_W-1:0] recip(input chan_t vmax);
        logic [RECIP_W-1:0] r;
        begin
            unique case (vmax)
                8'd1:    r = 26'd33554432;
                8'd3:    r = 26'd11184811;
                8'd7:    r = 26'd4793491;
                8'd15:   r = 26'd2236963;
                8'd31:   r = 26'd1082402;
                8'd63:   r = 26'd532611;
                default: r = 26'd131587;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== rtl/pixel_format_converter_unit.sv =====
// top level: config registers, decode, three scaling lanes, merge and pipeline control
// latency: a result passes through the input, numerator, quotient and output registers
// throughput: one pixel per cycle while m_ready holds, set by the four-stage pipeline with per-stage stall
// each stage holds one pixel, bubbles close up while the output register waits
// reset: synchronous active-low aresetn clears valid bits, source_format to rgb888,
//   target_format to rgb565; the datapath registers are not reset
module pixel_format_converter_unit
    import pfc_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic             cfg_addr,
    input  logic [FMT_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [PIX_W-1:0] s_pixel_in,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [PIX_W-1:0] m_pixel_out,
    output logic             m_not_grey
);

    fmt_t src_fmt_reg;
    fmt_t tgt_fmt_reg;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic v0_next, v1_next, v2_next, v3_next;
    logic acc, mv0, mv1, mv2, free0, free1, free2;

    chan_t [NUM_LANES-1:0] ch_next, mx_next, mout;
    chan_t [NUM_LANES-1:0] ch0_reg, mx0_reg, quo;
    fmt_t                  tgt0_reg, tgt1_reg, tgt2_reg;
    logic                  eq_next, eq1_reg, eq2_reg;
    logic [2*CHAN_W-1:0]   x01, x10, x02, x20;
    lane_ctl_t             lane_ctl;
    chan_t                 grey_mask;

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_fmt_reg <= RESET_SOURCE;
            tgt_fmt_reg <= RESET_TARGET;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_SOURCE_FORMAT: src_fmt_reg <= cfg_wr_data;
                REG_TARGET_FORMAT: tgt_fmt_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // source decode
    always_comb begin
        grey_mask = 8'd15;
        unique case (src_fmt_reg)
            FMT_RGB555: begin
                ch_next = {8'(s_pixel_in[4:0]), 8'(s_pixel_in[9:5]), 8'(s_pixel_in[14:10])};
                mx_next = {8'd31, 8'd31, 8'd31};
            end
            FMT_RGB565: begin
                ch_next = {8'(s_pixel_in[4:0]), 8'(s_pixel_in[10:5]), 8'(s_pixel_in[15:11])};
                mx_next = {8'd31, 8'd63, 8'd31};
            end
            FMT_RGB111: begin
                ch_next = {8'(s_pixel_in[0]), 8'(s_pixel_in[1]), 8'(s_pixel_in[2])};
                mx_next = {8'd1, 8'd1, 8'd1};
            end
            FMT_RGB222: begin
                ch_next = {8'(s_pixel_in[1:0]), 8'(s_pixel_in[3:2]), 8'(s_pixel_in[5:4])};
                mx_next = {8'd3, 8'd3, 8'd3};
            end
            FMT_GREY2,
            FMT_GREY3,
            FMT_GREY4: begin
                if (src_fmt_reg == FMT_GREY2) begin
                    grey_mask = 8'd3;
                end else if (src_fmt_reg == FMT_GREY3) begin
                    grey_mask = 8'd7;
                end
                ch_next = {3{s_pixel_in[7:0] & grey_mask}};
                mx_next = {3{grey_mask}};
            end
            default: begin
                ch_next = {s_pixel_in[7:0], s_pixel_in[15:8], s_pixel_in[23:16]};
                mx_next = {8'd255, 8'd255, 8'd255};
            end
        endcase
    end

    // pipeline control
    always_comb begin
        mv2     = v2_reg & (~v3_reg | m_ready);
        free2   = ~v2_reg | mv2;
        mv1     = v1_reg & free2;
        free1   = ~v1_reg | mv1;
        mv0     = v0_reg & free1;
        free0   = ~v0_reg | mv0;
        s_ready = free0;
        acc     = s_valid & free0;
        v0_next = acc | (v0_reg & ~mv0);
        v1_next = mv0 | (v1_reg & ~mv1);
        v2_next = mv1 | (v2_reg & ~mv2);
        v3_next = mv2 | (v3_reg & ~m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v0_reg <= v0_next;
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    // grey test by cross-multiplication of normalized channels
    always_comb begin
        x01     = ch0_reg[0] * mx0_reg[1];
        x10     = ch0_reg[1] * mx0_reg[0];
        x02     = ch0_reg[0] * mx0_reg[2];
        x20     = ch0_reg[2] * mx0_reg[0];
        eq_next = (x01 == x10) && (x02 == x20);
    end

    always_ff @(posedge aclk) begin
        if (acc) begin
            ch0_reg  <= ch_next;
            mx0_reg  <= mx_next;
            tgt0_reg <= tgt_fmt_reg;
        end
        if (mv0) begin
            tgt1_reg <= tgt0_reg;
            eq1_reg  <= eq_next;
        end
        if (mv1) begin
            tgt2_reg <= tgt1_reg;
            eq2_reg  <= eq1_reg;
        end
    end

    assign lane_ctl.load_num = mv0;
    assign lane_ctl.load_quo = mv1;

    for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
        assign mout[i] = target_max(tgt0_reg, 2'(i));

        pfc_lane u_lane (
            .aclk    (aclk),
            .ctl     (lane_ctl),
            .chan_in (ch0_reg[i]),
            .max_in  (mx0_reg[i]),
            .mout_in (mout[i]),
            .quo_out (quo[i])
        );
    end

    pfc_merge u_merge (
        .aclk       (aclk),
        .load       (mv2),
        .quo_in     (quo),
        .target_fmt (tgt2_reg),
        .chan_equal (eq2_reg),
        .pixel_out  (m_pixel_out),
        .not_grey   (m_not_grey)
    );

    assign m_valid = v3_reg;

    a_not_grey_pixel: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_not_grey) |-> (m_pixel_out == NOT_GREY_PIXEL))
        else $error("not_grey result without the 255 marker");

    a_full_when_blocked: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v0_reg && v1_reg && v2_reg && v3_reg))
        else $error("input stalled while a stage is empty");

    a_merge_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        mv2 |=> m_valid)
        else $error("merged result lost");

endmodule

// ===== rtl/pfc_lane.sv =====
// one channel lane: rounded rescale of a channel value by two maxima
module pfc_lane
    import pfc_pkg::*;
(
    input  logic      aclk,
    input  lane_ctl_t ctl,
    input  chan_t     chan_in,
    input  chan_t     max_in,
    input  chan_t     mout_in,
    output chan_t     quo_out
);

    logic [NUM_W-1:0]            num_reg;
    logic [NUM_W-1:0]            num_next;
    chan_t                       max_reg;
    chan_t                       quo_reg;
    logic [2*CHAN_W-1:0]         prod_small;
    logic [NUM_W+RECIP_W-1:0]    prod_wide;

    // numerator of round-half-up: 2*v*mout + vmax
    always_comb begin
        prod_small = chan_in * mout_in;
        num_next   = {prod_small, 1'b0} + NUM_W'(max_in);
    end

    assign prod_wide = (NUM_W+RECIP_W)'(num_reg) * (NUM_W+RECIP_W)'(recip(max_reg));

    always_ff @(posedge aclk) begin
        if (ctl.load_num) begin
            num_reg <= num_next;
            max_reg <= max_in;
        end
        if (ctl.load_quo) begin
            quo_reg <= prod_wide[RECIP_SH +: CHAN_W];
        end
    end

    assign quo_out = quo_reg;

endmodule

// ===== rtl/pfc_merge.sv =====
// merge stage: packs lane results into the target layout, output register
module pfc_merge
    import pfc_pkg::*;
(
    input  logic                        aclk,
    input  logic                        load,
    input  chan_t [NUM_LANES-1:0]       quo_in,
    input  fmt_t                        target_fmt,
    input  logic                        chan_equal,
    output logic [PIX_W-1:0]            pixel_out,
    output logic                        not_grey
);

    logic [PIX_W-1:0] pixel_reg;
    logic [PIX_W-1:0] pixel_next;
    logic             not_grey_reg;
    logic             not_grey_next;

    always_comb begin
        pixel_next    = '0;
        not_grey_next = 1'b0;
        unique case (target_fmt)
            FMT_RGB555: pixel_next = {17'd0, quo_in[0][4:0], quo_in[1][4:0], quo_in[2][4:0]};
            FMT_RGB565: pixel_next = {16'd0, quo_in[0][4:0], quo_in[1][5:0], quo_in[2][4:0]};
            FMT_RGB888: pixel_next = {8'd0, quo_in[0], quo_in[1], quo_in[2]};
            FMT_ARGB:   pixel_next = {ALPHA_OPAQUE, quo_in[0], quo_in[1], quo_in[2]};
            FMT_RGB111: pixel_next = {29'd0, quo_in[0][0], quo_in[1][0], quo_in[2][0]};
            FMT_RGB222: pixel_next = {26'd0, quo_in[0][1:0], quo_in[1][1:0], quo_in[2][1:0]};
            FMT_GREY2,
            FMT_GREY3,
            FMT_GREY4: begin
                if (chan_equal) begin
                    pixel_next = {24'd0, quo_in[0]};
                end else begin
                    pixel_next    = NOT_GREY_PIXEL;
                    not_grey_next = 1'b1;
                end
            end
            default: pixel_next = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pixel_reg    <= pixel_next;
            not_grey_reg <= not_grey_next;
        end
    end

    assign pixel_out = pixel_reg;
    assign not_grey  = not_grey_reg;

endmodule
